// ----- sv/dmc_pkg.sv -----
// Shared types and constants for the direct-mapped cache.
package dmc_pkg;

	localparam int LINES     = 16;
	localparam int WORDS     = 16;
	localparam int IDX_W     = $clog2(LINES);
	localparam int WORD_W    = $clog2(WORDS);
	localparam int TAG_W     = 32 - 2 - IDX_W - WORD_W;
	localparam int DADDR_W   = IDX_W + WORD_W;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_FILL  = 2'd2;

	typedef enum logic [2:0] {
		KIND_RDATA,
		KIND_WDONE,
		KIND_WB,
		KIND_WT,
		KIND_FREQ,
		KIND_ERR
	} kind_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] address;
		logic [31:0] data_word;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] out_address;
		logic [31:0] out_data;
		logic        hit;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WB_RD,
		ST_WB_EMIT,
		ST_FILL_REQ,
		ST_FILL_FIN,
		ST_RD_DONE,
		ST_WT,
		ST_WDONE,
		ST_ERR
	} state_t;

endpackage

// ----- sv/dmc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dmc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/direct_mapped_cache_core.sv -----
// Direct-mapped write-back/write-through cache, 16 lines of 16 words, with one beat at a time.
// One item is handled at a time. A hit passes through accept, the tag and data RAM read and
// the result register. A dirty miss streams 16 writeback beats, each a line RAM read and then
// an emit, then a fill request beat. Fill words are taken while idle; after the last one the
// access finishes through ST_FILL_FIN and its read, write-through or write-done beats.
// Each result beat waits while rsp_stall is high.
module direct_mapped_cache_core
	import dmc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	state_t state_q, state_d;
	logic write_back_q;
	logic [LINES-1:0] valid_q, dirty_q;
	logic fill_pending_q;
	logic [WORD_W-1:0] cnt_q;
	logic acc_write_q;
	logic [31:0] acc_addr_q, acc_data_q;
	logic hit_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic accept, out_free, emit;
	rsp_t emit_val;
	logic req_err;

	logic d_we, d_re;
	logic [DADDR_W-1:0] d_waddr, d_raddr;
	logic [31:0] d_wdata, d_rdata;
	logic t_we, t_re;
	logic [TAG_W-1:0] t_rdata;

	logic [IDX_W-1:0]  acc_idx, req_idx;
	logic [WORD_W-1:0] acc_word, req_word;
	logic [TAG_W-1:0]  acc_tag;
	logic lookup_hit, fill_last;

	assign acc_word = acc_addr_q[2 +: WORD_W];
	assign acc_idx  = acc_addr_q[2 + WORD_W +: IDX_W];
	assign acc_tag  = acc_addr_q[31 -: TAG_W];
	assign req_word = req.address[2 +: WORD_W];
	assign req_idx  = req.address[2 + WORD_W +: IDX_W];

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_err = (req.mode != MODE_READ && req.mode != MODE_WRITE && req.mode != MODE_FILL)
		|| (req.mode == MODE_FILL && !fill_pending_q)
		|| (req.mode != MODE_FILL && fill_pending_q);
	assign lookup_hit = valid_q[acc_idx] && (t_rdata == acc_tag);
	assign fill_last  = (cnt_q == WORD_W'(WORDS - 1));

	dmc_ram #(.WIDTH(32), .DEPTH(LINES * WORDS)) u_data_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	dmc_ram #(.WIDTH(TAG_W), .DEPTH(LINES)) u_tag_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (acc_idx),
		.wdata (acc_tag),
		.re    (t_re),
		.raddr (req_idx),
		.rdata (t_rdata)
	);

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		emit_val = '{kind: KIND_ERR, out_address: '0, out_data: '0, hit: 1'b0, last: 1'b1};
		d_we     = 1'b0;
		d_waddr  = {acc_idx, acc_word};
		d_wdata  = acc_data_q;
		d_re     = 1'b0;
		d_raddr  = {req_idx, req_word};
		t_we     = 1'b0;
		t_re     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_err) begin
						state_d = ST_ERR;
					end else if (req.mode == MODE_FILL) begin
						d_we    = 1'b1;
						d_waddr = {acc_idx, cnt_q};
						d_wdata = req.data_word;
						if (fill_last) begin
							state_d = ST_FILL_FIN;
						end
					end else begin
						d_re    = 1'b1;
						t_re    = 1'b1;
						state_d = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				if (lookup_hit) begin
					if (!acc_write_q) begin
						if (out_free) begin
							emit = 1'b1;
							emit_val = '{kind: KIND_RDATA, out_address: '0, out_data: d_rdata,
								hit: 1'b1, last: 1'b1};
							state_d = ST_IDLE;
						end
					end else if (write_back_q) begin
						if (out_free) begin
							d_we = 1'b1;
							emit = 1'b1;
							emit_val = '{kind: KIND_WDONE, out_address: '0, out_data: '0,
								hit: 1'b1, last: 1'b1};
							state_d = ST_IDLE;
						end
					end else begin
						d_we    = 1'b1;
						state_d = ST_WT;
					end
				end else if (valid_q[acc_idx] && dirty_q[acc_idx]) begin
					state_d = ST_WB_RD;
				end else begin
					state_d = ST_FILL_REQ;
				end
			end
			ST_WB_RD: begin
				d_re    = 1'b1;
				d_raddr = {acc_idx, cnt_q};
				state_d = ST_WB_EMIT;
			end
			ST_WB_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					emit_val = '{kind: KIND_WB, out_address: {t_rdata, acc_idx, cnt_q, 2'b00},
						out_data: d_rdata, hit: 1'b0, last: 1'b0};
					state_d = fill_last ? ST_FILL_REQ : ST_WB_RD;
				end
			end
			ST_FILL_REQ: begin
				if (out_free) begin
					t_we = 1'b1;
					emit = 1'b1;
					emit_val = '{kind: KIND_FREQ,
						out_address: {acc_tag, acc_idx, {WORD_W{1'b0}}, 2'b00},
						out_data: '0, hit: 1'b0, last: 1'b1};
					state_d = ST_IDLE;
				end
			end
			ST_FILL_FIN: begin
				if (acc_write_q) begin
					d_we    = 1'b1;
					state_d = write_back_q ? ST_WDONE : ST_WT;
				end else begin
					d_re    = 1'b1;
					d_raddr = {acc_idx, acc_word};
					state_d = ST_RD_DONE;
				end
			end
			ST_RD_DONE: begin
				if (out_free) begin
					emit = 1'b1;
					emit_val = '{kind: KIND_RDATA, out_address: '0, out_data: d_rdata,
						hit: 1'b0, last: 1'b1};
					state_d = ST_IDLE;
				end
			end
			ST_WT: begin
				if (out_free) begin
					emit = 1'b1;
					emit_val = '{kind: KIND_WT, out_address: {acc_addr_q[31:2], 2'b00},
						out_data: acc_data_q, hit: hit_q, last: 1'b0};
					state_d = ST_WDONE;
				end
			end
			ST_WDONE: begin
				if (out_free) begin
					emit = 1'b1;
					emit_val = '{kind: KIND_WDONE, out_address: '0, out_data: '0,
						hit: hit_q, last: 1'b1};
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_back_q   <= 1'b1;
			valid_q        <= '0;
			dirty_q        <= '0;
			fill_pending_q <= 1'b0;
			cnt_q          <= '0;
			acc_write_q    <= 1'b0;
			acc_addr_q     <= '0;
			acc_data_q     <= '0;
			hit_q          <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				write_back_q <= cfg_data;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			// The access registers double as the pending-miss record until the fill ends.
			if (accept && !req_err && req.mode != MODE_FILL) begin
				acc_write_q <= (req.mode == MODE_WRITE);
				acc_addr_q  <= req.address;
				acc_data_q  <= req.data_word;
			end
			if (state_q == ST_IDLE && accept && !req_err && req.mode == MODE_FILL) begin
				cnt_q <= cnt_q + WORD_W'(1);
				if (fill_last) begin
					fill_pending_q   <= 1'b0;
					valid_q[acc_idx] <= 1'b1;
					hit_q            <= 1'b0;
				end
			end
			if (state_q == ST_LOOKUP) begin
				hit_q <= lookup_hit;
				if (lookup_hit && acc_write_q && write_back_q && out_free) begin
					dirty_q[acc_idx] <= 1'b1;
				end
			end
			if (state_q == ST_WB_EMIT && out_free) begin
				cnt_q <= cnt_q + WORD_W'(1);
			end
			if (state_q == ST_FILL_REQ && out_free) begin
				valid_q[acc_idx] <= 1'b0;
				dirty_q[acc_idx] <= 1'b0;
				fill_pending_q   <= 1'b1;
				cnt_q            <= '0;
			end
			if (state_q == ST_FILL_FIN && acc_write_q && write_back_q) begin
				dirty_q[acc_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_val;
		end
	end

	a_pend_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		fill_pending_q |-> !valid_q[acc_idx])
		else $error("line under fill is marked valid");

	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(dirty_q & ~valid_q) == '0)
		else $error("dirty bit set on an invalid line");

	a_wb_victim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WB_EMIT |-> valid_q[acc_idx] && dirty_q[acc_idx] && !fill_pending_q)
		else $error("writeback of a line that is not a dirty victim");

	a_fill_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL_FIN |-> valid_q[acc_idx] && !fill_pending_q && cnt_q == '0)
		else $error("fill finished without validating the line");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the direct-mapped cache core.
`timescale 1ns / 100ps

class cache_scoreboard;
	dmc_pkg::rsp_t pending_rsp[$];
	bit            policy_wb;
	logic [21:0]   tags[16];
	bit            valid_q[16];
	bit            dirty_q[16];
	logic [31:0]   words[256];
	bit            miss_is_write;
	logic [31:0]  miss_addr;
	logic [31:0]  miss_value;
	int unsigned   fill_cnt;
	bit            filling;
	int            mismatches;
	int            checked;

	function new();
		policy_wb = 1'b1;
		miss_is_write = 0;
		miss_addr = '0;
		miss_value = '0;
		fill_cnt = 0;
		filling = 0;
		mismatches = 0;
		checked = 0;
		for (int i = 0; i < 16; i++) begin
			valid_q[i] = 0;
			dirty_q[i] = 0;
			tags[i] = '0;
		end
	endfunction

	function void push(dmc_pkg::kind_t k, logic [31:0] a, logic [31:0] d, bit h, bit l);
		dmc_pkg::rsp_t r;
		r.kind = k;
		r.out_address = a;
		r.out_data = d;
		r.hit = h;
		r.last = l;
		pending_rsp.push_back(r);
	endfunction

	function void finish_store(int idx, int w, logic [31:0] a, logic [31:0] v, bit h);
		words[idx * 16 + w] = v;
		if (policy_wb) dirty_q[idx] = 1;
		else push(dmc_pkg::KIND_WT, {a[31:2], 2'b00}, v, h, 0);
		push(dmc_pkg::KIND_WDONE, '0, '0, h, 1);
	endfunction

	// Works out the result beats caused by one accepted request.
	function void note_request(dmc_pkg::req_t q);
		int idx, w;
		logic [21:0] tg;
		if (q.mode == dmc_pkg::MODE_FILL && filling) begin
			idx = miss_addr[9:6];
			words[idx * 16 + fill_cnt] = q.data_word;
			fill_cnt++;
			if (fill_cnt < 16) return;
			fill_cnt = 0;
			filling = 0;
			valid_q[idx] = 1;
			w = miss_addr[5:2];
			if (miss_is_write) finish_store(idx, w, miss_addr, miss_value, 0);
			else push(dmc_pkg::KIND_RDATA, '0, words[idx * 16 + w], 0, 1);
			return;
		end
		if (q.mode > dmc_pkg::MODE_WRITE || filling) begin
			push(dmc_pkg::KIND_ERR, '0, '0, 0, 1);
			return;
		end
		idx = q.address[9:6];
		w = q.address[5:2];
		tg = q.address[31:10];
		if (valid_q[idx] && tags[idx] == tg) begin
			if (q.mode == dmc_pkg::MODE_WRITE) finish_store(idx, w, q.address, q.data_word, 1);
			else push(dmc_pkg::KIND_RDATA, '0, words[idx * 16 + w], 1, 1);
			return;
		end
		if (valid_q[idx] && dirty_q[idx])
			for (int i = 0; i < 16; i++)
				push(dmc_pkg::KIND_WB, {tags[idx], idx[3:0], i[3:0], 2'b00},
					words[idx * 16 + i], 0, 0);
		dirty_q[idx] = 0;
		valid_q[idx] = 0;
		tags[idx] = tg;
		miss_is_write = (q.mode == dmc_pkg::MODE_WRITE);
		miss_addr = q.address;
		miss_value = q.data_word;
		fill_cnt = 0;
		filling = 1;
		push(dmc_pkg::KIND_FREQ, {tg, idx[3:0], 6'd0}, '0, 0, 1);
	endfunction

	function void check_response(dmc_pkg::rsp_t got);
		dmc_pkg::rsp_t want;
		if (pending_rsp.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("Unexpected response beat %p", got);
			return;
		end
		want = pending_rsp.pop_front();
		checked++;
		if (got.kind !== want.kind || got.out_address !== want.out_address ||
				got.out_data !== want.out_data || got.hit !== want.hit ||
				got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
		end
	endfunction
endclass

module testbench;
	import dmc_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	cache_scoreboard board;
	int send_idle_pct;
	int stall_pct;
	bit hold_rsp;
	int cycle_count;
	int n_reads, n_writes, n_fills;

	direct_mapped_cache_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver: random stall, or a long hold while hold_rsp is set.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall && arst_n) board.check_response(rsp);
		rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
	end

	// The beat stays offered after acceptance until the next send, an idle cycle or a drain.
	task automatic send(logic [1:0] m, logic [31:0] a, logic [31:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req.mode <= m;
		req.address <= a;
		req.data_word <= d;
		do @(posedge clk); while (req_stall);
		board.note_request('{mode: m, address: a, data_word: d});
		if (m == MODE_READ) n_reads++;
		else if (m == MODE_WRITE) n_writes++;
		else n_fills++;
	endtask

	task automatic drain();
		req_valid <= 0;
		while (board.pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_policy(bit wb);
		cfg_valid <= 1;
		cfg_data <= wb;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.policy_wb = wb;
	endtask

	task automatic fill_line();
		for (int i = 0; i < 16; i++) send(MODE_FILL, $urandom, $urandom);
	endtask

	// One access; completes any miss with a line fill.
	task automatic access(logic [1:0] m, logic [31:0] a, logic [31:0] d);
		send(m, a, d);
		if (board.filling) fill_line();
	endtask

	function automatic logic [31:0] pick_addr();
		logic [31:0] a;
		a = $urandom;
		// Mostly two tags over four lines so hits and dirty evictions are common.
		a[9:8] = 2'b00;
		a[31:10] = $urandom_range(1) ? 22'h3fffff : 22'h0;
		if ($urandom_range(9) == 0) a[31:10] = 22'($urandom);
		return a;
	endfunction

	task automatic random_phase(int count, int sidle, int rstall);
		int r;
		send_idle_pct = sidle;
		stall_pct = rstall;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(19);
			if (r == 0) send(MODE_FILL, $urandom, $urandom);
			else if (r == 1) send(2'd3, $urandom, $urandom);
			else if (r == 2) begin
				send(MODE_READ, pick_addr(), $urandom);
				if (board.filling) begin
					send(2'($urandom_range(1)), $urandom, $urandom);
					fill_line();
				end
			end else access(2'($urandom_range(1)), pick_addr(), $urandom);
		end
		drain();
	endtask

	initial begin
		board = new();
		arst_n = 0;
		req_valid = 0;
		req = '0;
		cfg_valid = 0;
		cfg_data = 1;
		hold_rsp = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		n_reads = 0;
		n_writes = 0;
		n_fills = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: stray fill, unused mode, miss/hit, dirty eviction, errors during fill.
		set_policy(1);
		send(MODE_FILL, 32'hffffffff, 32'hffffffff);
		send(2'd3, 32'hffffffff, 32'h0);
		access(MODE_READ, 32'h0000_0003, 0);
		access(MODE_WRITE, 32'h0000_0005, 32'hffffffff);
		access(MODE_READ, 32'h0000_0004, 0);
		send(MODE_WRITE, 32'hffff_ffc1, 32'h1234_5678);
		send(MODE_READ, 32'h0, 0);
		send(MODE_WRITE, 32'h0, 0);
		fill_line();
		access(MODE_READ, 32'h0000_0400, 0);
		drain();
		set_policy(0);
		access(MODE_WRITE, 32'hffff_ffc0, 32'hdead_beef);
		access(MODE_WRITE, 32'h0000_0404, 32'h0);
		access(MODE_READ, 32'h0000_0404, 0);
		access(MODE_READ, 32'h0000_0000, 0);
		// A write miss whose policy flips before the fill completes.
		send(MODE_WRITE, 32'h0000_0840, 32'h5555_aaaa);
		drain();
		set_policy(1);
		fill_line();
		drain();

		// Long receiver hold while the sender keeps offering.
		fork
			begin
				hold_rsp = 1;
				repeat (300) @(posedge clk);
				hold_rsp = 0;
			end
			for (int i = 0; i < 3; i++) access(MODE_WRITE, pick_addr(), $urandom);
		join
		drain();

		random_phase(6, 0, 0);
		set_policy(0);
		random_phase(6, 86, 0);
		set_policy(1);
		random_phase(6, 0, 86);
		set_policy(1'($urandom_range(1)));
		random_phase(6, 22, 22);

		$display("Covered %0d reads, %0d writes, %0d fill/other beats; %0d results checked.",
			n_reads, n_writes, n_fills, board.checked);
		if (board.mismatches == 0 && board.pending_rsp.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/dmc_pkg.sv
sv/dmc_ram.sv
sv/direct_mapped_cache_core.sv
sim/testbench.sv
